### sv/ids_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ids_pkg
// Shared widths, register indexes and constants of the ignition dwell
// scheduler.
// ----------------------------------------------------------------------------
package ids_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_ADVANCE = 3'd0;
  localparam logic [2:0] REG_DWELL   = 3'd1;
  localparam logic [2:0] REG_ENABLE  = 3'd2;
  localparam logic [2:0] REG_CUT     = 3'd3;
  localparam logic [2:0] REG_MODE    = 3'd4;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 13;

  // clamp ranges and reset values
  localparam logic [8:0]  ADV_MIN   = 9'd50;
  localparam logic [8:0]  ADV_MAX   = 9'd400;
  localparam logic [8:0]  ADV_RST   = 9'd100;
  localparam logic [12:0] DWELL_MIN = 13'd1000;
  localparam logic [12:0] DWELL_MAX = 13'd5000;
  localparam logic [12:0] DWELL_RST = 13'd3500;

  // trigger modes
  localparam logic MODE_DISTRIBUTOR = 1'b0;
  localparam logic MODE_SIXTY_TOOTH = 1'b1;

  // charging coil codes
  localparam logic [1:0] COIL_NONE = 2'd0;
  localparam logic [1:0] COIL_A    = 2'd1;
  localparam logic [1:0] COIL_B    = 2'd2;

  localparam logic [7:0] TOOTH_RST       = 8'd255;
  localparam logic [7:0] TEETH_PER_EVENT = 8'd30;

  // divider widths: dividend covers one minute in us, divisor covers rpm
  localparam int QW = 26;
  localparam int DW = 16;

  localparam logic [QW-1:0] US_PER_MIN   = 26'd60000000;
  localparam logic [DW-1:0] DEG_PER_REV  = 16'd360;
  localparam logic [DW-1:0] TENTHS       = 16'd10;
  localparam logic [15:0]   RPM_MIN      = 16'd50;
  localparam logic [20:0]   ROUND_TENTHS = 21'd9;

  // reciprocals, exact for any dividend below 2^21
  localparam logic [21:0] RECIP_DEG       = 22'd2982617;
  localparam int          RECIP_DEG_SH    = 30;
  localparam logic [20:0] RECIP_TENTHS    = 21'd1677722;
  localparam int          RECIP_TENTHS_SH = 24;

  // one bit per tooth index, set on the multiples of TEETH_PER_EVENT
  function automatic logic [255:0] event_teeth();
    logic [255:0] m;
    m = '0;
    for (int i = 0; i < 256; i += int'(TEETH_PER_EVENT)) begin
      m[i] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [255:0] EVENT_TEETH = event_teeth();

endpackage

### sv/ignition_dwell_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ignition_dwell_scheduler
// Coil dwell and spark timing for one or two ignition coils.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one update tick per transfer (time, rpm, tooth, pulse time in
//           tdata, decoder sync flag in tuser).
//   out_* : one transfer per tick with the two coil drive levels.
//   cfg_* : register writes, taken at once while the block is idle.
// Sequence:
//   distributor mode, unblocked: the accept step, a 26 step radix-2
//   restoring divider for 60e6/rpm, the steps on one shared multiplier
//   (reciprocal /360, advance product, reciprocal /10), a prepare and an
//   update step.
//   sixty tooth mode or a blocked tick: accept and update only.
//   in_tready is high only while the sequencer is idle; one tick at a time.
// Reset (rst_n low, synchronous): configuration registers return to their
//   defaults, coils low, no dwell, no result pending.
// Stall: a finished result waits in the output register; the next tick may
//   be taken and worked on, and its update waits until that register frees.
// ----------------------------------------------------------------------------
module ignition_dwell_scheduler (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // now_us[31:0], engine_rpm[47:32], tooth_number[55:48], pulse_time_us[87:56]
  input  logic [87:0]               in_tdata,
  // sync_ok[0]
  input  logic [0:0]                in_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // coil_a_on[0], coil_b_on[1], zero fill[7:2]
  output logic [7:0]                out_tdata,
  input  logic                      cfg_we,
  input  logic [ids_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [ids_pkg::CFG_DW-1:0] cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_DEG  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_TEN  = 7'b0010000,
    S_PREP = 7'b0100000,
    S_EVAL = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [8:0]  adv_r, adv_nxt;
  logic [12:0] dwell_r, dwell_nxt;
  logic        en_r, en_nxt;
  logic        cut_r, cut_nxt;
  logic        mode_r, mode_nxt;

  // latched tick
  logic [31:0] now_r, now_nxt;
  logic [15:0] rpm_r, rpm_nxt;
  logic        sync_r, sync_nxt;
  logic [7:0]  tooth_r, tooth_nxt;
  logic [31:0] pulse_r, pulse_nxt;

  // divider
  logic [ids_pkg::DW-1:0] div_rem_r, div_rem_nxt;
  logic [ids_pkg::QW-1:0] div_quo_r, div_quo_nxt;
  logic [ids_pkg::DW-1:0] div_den_r, div_den_nxt;
  logic [4:0]             div_cnt_r, div_cnt_nxt;
  logic [ids_pkg::DW:0]   div_sh, div_diff;
  logic                   div_ge;
  logic [ids_pkg::QW-1:0] div_q;

  // shared multiplier
  logic [20:0] mul_a;
  logic [21:0] mul_b;
  logic [42:0] mul_p;

  // intermediate results
  logic [20:0] per_rev_r, per_rev_nxt;
  logic [11:0] per_deg_r, per_deg_nxt;
  logic [20:0] prod_r, prod_nxt;
  logic [17:0] adv_us_r, adv_us_nxt;
  logic [31:0] start_at_r, start_at_nxt;

  // engine state
  logic [31:0] seen_pulse_r, seen_pulse_nxt;
  logic [31:0] dwell_start_r, dwell_start_nxt;
  logic        dwell_on_r, dwell_on_nxt;
  logic [1:0]  coil_r, coil_nxt;
  logic [7:0]  seen_tooth_r, seen_tooth_nxt;
  logic        alt_r, alt_nxt;
  logic        lvl_a_r, lvl_a_nxt;
  logic        lvl_b_r, lvl_b_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_coils_r, out_coils_nxt;

  logic        blocked_in, blocked;
  logic        out_free;
  logic [8:0]  cfg_adv;
  logic [12:0] cfg_dwell;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_coils_r};
  assign out_free   = !out_valid_r || out_tready;

  assign blocked_in = !en_r || cut_r || !in_tuser[0] || (in_tdata[47:32] < ids_pkg::RPM_MIN);
  assign blocked    = !en_r || cut_r || !sync_r || (rpm_r < ids_pkg::RPM_MIN);

  // restoring divider step
  assign div_sh   = {div_rem_r, div_quo_r[ids_pkg::QW-1]};
  assign div_ge   = (div_sh >= {1'b0, div_den_r});
  assign div_diff = div_sh - {1'b0, div_den_r};
  assign div_q    = {div_quo_r[ids_pkg::QW-2:0], div_ge};

  // multiplier operands follow the sequencer step
  always_comb begin
    mul_a = per_rev_r;
    mul_b = ids_pkg::RECIP_DEG;
    case (state_r)
      S_MUL: begin
        mul_a = {12'd0, adv_r};
        mul_b = {10'd0, per_deg_r};
      end
      S_TEN: begin
        mul_a = prod_r;
        mul_b = {1'b0, ids_pkg::RECIP_TENTHS};
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign cfg_adv = (cfg_wdata[8:0] < ids_pkg::ADV_MIN) ? ids_pkg::ADV_MIN :
                   (cfg_wdata[8:0] > ids_pkg::ADV_MAX) ? ids_pkg::ADV_MAX : cfg_wdata[8:0];
  assign cfg_dwell = (cfg_wdata < ids_pkg::DWELL_MIN) ? ids_pkg::DWELL_MIN :
                     (cfg_wdata > ids_pkg::DWELL_MAX) ? ids_pkg::DWELL_MAX : cfg_wdata;

  always_comb begin
    logic        pulse_new;
    logic        dw_mid;
    logic        a_mid;
    logic        b_mid;
    logic [31:0] st_mid;
    logic [1:0]  coil_mid;
    logic        alt_mid;

    state_nxt       = state_r;
    adv_nxt         = adv_r;
    dwell_nxt       = dwell_r;
    en_nxt          = en_r;
    cut_nxt         = cut_r;
    mode_nxt        = mode_r;
    now_nxt         = now_r;
    rpm_nxt         = rpm_r;
    sync_nxt        = sync_r;
    tooth_nxt       = tooth_r;
    pulse_nxt       = pulse_r;
    div_rem_nxt     = div_rem_r;
    div_quo_nxt     = div_quo_r;
    div_den_nxt     = div_den_r;
    div_cnt_nxt     = div_cnt_r;
    per_rev_nxt     = per_rev_r;
    per_deg_nxt     = per_deg_r;
    prod_nxt        = prod_r;
    adv_us_nxt      = adv_us_r;
    start_at_nxt    = start_at_r;
    seen_pulse_nxt  = seen_pulse_r;
    dwell_start_nxt = dwell_start_r;
    dwell_on_nxt    = dwell_on_r;
    coil_nxt        = coil_r;
    seen_tooth_nxt  = seen_tooth_r;
    alt_nxt         = alt_r;
    lvl_a_nxt       = lvl_a_r;
    lvl_b_nxt       = lvl_b_r;
    out_valid_nxt   = out_valid_r;
    out_coils_nxt   = out_coils_r;
    pulse_new       = 1'b0;
    dw_mid          = dwell_on_r;
    a_mid           = lvl_a_r;
    b_mid           = lvl_b_r;
    st_mid          = dwell_start_r;
    coil_mid        = coil_r;
    alt_mid         = alt_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          now_nxt   = in_tdata[31:0];
          rpm_nxt   = in_tdata[47:32];
          tooth_nxt = in_tdata[55:48];
          pulse_nxt = in_tdata[87:56];
          sync_nxt  = in_tuser[0];
          if (!blocked_in && mode_r == ids_pkg::MODE_DISTRIBUTOR) begin
            div_rem_nxt = '0;
            div_quo_nxt = ids_pkg::US_PER_MIN;
            div_den_nxt = in_tdata[47:32];
            div_cnt_nxt = 5'(ids_pkg::QW - 1);
            state_nxt   = S_DIV;
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_DIV: begin
        div_rem_nxt = div_ge ? div_diff[ids_pkg::DW-1:0] : div_sh[ids_pkg::DW-1:0];
        div_quo_nxt = div_q;
        div_cnt_nxt = div_cnt_r - 5'd1;
        if (div_cnt_r == 5'd0) begin
          per_rev_nxt = div_q[20:0];
          state_nxt   = S_DEG;
        end
      end
      S_DEG: begin
        per_deg_nxt = mul_p[ids_pkg::RECIP_DEG_SH +: 12];
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = mul_p[20:0] + ids_pkg::ROUND_TENTHS;
        state_nxt = S_TEN;
      end
      S_TEN: begin
        adv_us_nxt = mul_p[ids_pkg::RECIP_TENTHS_SH +: 18];
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        // start offset wraps when the spark target is shorter than the dwell
        start_at_nxt = {11'd0, per_rev_r} - {14'd0, adv_us_r} - {19'd0, dwell_r};
        state_nxt    = S_EVAL;
      end
      S_EVAL: begin
        if (out_free) begin
          if (blocked) begin
            a_mid  = 1'b0;
            b_mid  = 1'b0;
            dw_mid = 1'b0;
          end else if (mode_r == ids_pkg::MODE_DISTRIBUTOR) begin
            pulse_new      = (pulse_r != seen_pulse_r);
            seen_pulse_nxt = pulse_r;
            if (pulse_new && dwell_on_r) begin
              a_mid  = 1'b0;
              dw_mid = 1'b0;
            end
            if (!dw_mid) begin
              if ((now_r - pulse_r) >= start_at_r) begin
                a_mid    = 1'b1;
                dw_mid   = 1'b1;
                st_mid   = now_r;
                coil_mid = ids_pkg::COIL_A;
              end
            end else if ((now_r - dwell_start_r) >= {19'd0, dwell_r}) begin
              // coil A only in this mode, whatever coil was charging
              a_mid  = 1'b0;
              dw_mid = 1'b0;
            end
          end else begin
            if (tooth_r != seen_tooth_r) begin
              seen_tooth_nxt = tooth_r;
              if (ids_pkg::EVENT_TEETH[tooth_r] && !dwell_on_r) begin
                alt_mid  = !alt_r;
                coil_mid = alt_mid ? ids_pkg::COIL_A : ids_pkg::COIL_B;
                if (alt_mid) begin
                  a_mid = 1'b1;
                end else begin
                  b_mid = 1'b1;
                end
                dw_mid = 1'b1;
                st_mid = now_r;
              end
            end
            if (dw_mid && (now_r - st_mid) >= {19'd0, dwell_r}) begin
              if (coil_mid == ids_pkg::COIL_A) begin
                a_mid = 1'b0;
              end else begin
                b_mid = 1'b0;
              end
              dw_mid = 1'b0;
            end
          end
          lvl_a_nxt       = a_mid;
          lvl_b_nxt       = b_mid;
          dwell_on_nxt    = dw_mid;
          dwell_start_nxt = st_mid;
          coil_nxt        = coil_mid;
          alt_nxt         = alt_mid;
          out_valid_nxt   = 1'b1;
          out_coils_nxt   = {b_mid, a_mid};
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      case (cfg_addr)
        ids_pkg::REG_ADVANCE: adv_nxt = cfg_adv;
        ids_pkg::REG_DWELL:   dwell_nxt = cfg_dwell;
        ids_pkg::REG_ENABLE: begin
          en_nxt = cfg_wdata[0];
          if (!cfg_wdata[0]) begin
            lvl_a_nxt    = 1'b0;
            lvl_b_nxt    = 1'b0;
            dwell_on_nxt = 1'b0;
          end
        end
        ids_pkg::REG_CUT:  cut_nxt = cfg_wdata[0];
        ids_pkg::REG_MODE: mode_nxt = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      adv_r         <= ids_pkg::ADV_RST;
      dwell_r       <= ids_pkg::DWELL_RST;
      en_r          <= 1'b1;
      cut_r         <= 1'b0;
      mode_r        <= ids_pkg::MODE_SIXTY_TOOTH;
      div_cnt_r     <= '0;
      seen_pulse_r  <= '0;
      dwell_start_r <= '0;
      dwell_on_r    <= 1'b0;
      coil_r        <= ids_pkg::COIL_NONE;
      seen_tooth_r  <= ids_pkg::TOOTH_RST;
      alt_r         <= 1'b0;
      lvl_a_r       <= 1'b0;
      lvl_b_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      adv_r         <= adv_nxt;
      dwell_r       <= dwell_nxt;
      en_r          <= en_nxt;
      cut_r         <= cut_nxt;
      mode_r        <= mode_nxt;
      div_cnt_r     <= div_cnt_nxt;
      seen_pulse_r  <= seen_pulse_nxt;
      dwell_start_r <= dwell_start_nxt;
      dwell_on_r    <= dwell_on_nxt;
      coil_r        <= coil_nxt;
      seen_tooth_r  <= seen_tooth_nxt;
      alt_r         <= alt_nxt;
      lvl_a_r       <= lvl_a_nxt;
      lvl_b_r       <= lvl_b_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    rpm_r       <= rpm_nxt;
    sync_r      <= sync_nxt;
    tooth_r     <= tooth_nxt;
    pulse_r     <= pulse_nxt;
    div_rem_r   <= div_rem_nxt;
    div_quo_r   <= div_quo_nxt;
    div_den_r   <= div_den_nxt;
    per_rev_r   <= per_rev_nxt;
    per_deg_r   <= per_deg_nxt;
    prod_r      <= prod_nxt;
    adv_us_r    <= adv_us_nxt;
    start_at_r  <= start_at_nxt;
    out_coils_r <= out_coils_nxt;
  end

endmodule

### sv/ids_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ids_checker
// Port level checks of the ignition dwell scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ids_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // nothing pending after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // one tick at a time: busy in the cycle after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a tick is in progress");

  // fill bits of the result stay zero
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'd0)
    else $error("nonzero fill bits in result");

endmodule

bind ignition_dwell_scheduler ids_checker u_ids_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/tb_ignition_dwell_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ignition_dwell_scheduler
// Self-checking bench for the coil dwell and spark timing block. Each tick
// sent is also run through a cycle-free predictor of the coil levels. Every
// result transfer is compared with the oldest predicted pair. Directed ticks
// cover tooth events, register clamping and the distributor window. Random
// ticks follow a simulated crank wheel or distributor with noise mixed in,
// and both handshakes are paced at random.
// ----------------------------------------------------------------------------
module tb_ignition_dwell_scheduler;
  import ids_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 100;
  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [31:0] now_us;
    logic [15:0] rpm;
    logic        sync_ok;
    logic [7:0]  tooth;
    logic [31:0] pulse_us;
  } tick_t;

  // coil_a in bit 0, as on out_tdata
  typedef struct packed {
    logic coil_b;
    logic coil_a;
  } coils_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  // now_us[31:0], engine_rpm[47:32], tooth_number[55:48], pulse_time_us[87:56]
  logic [87:0]       in_tdata = '0;
  // sync_ok[0]
  logic [0:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  // coil_a_on[0], coil_b_on[1], zero fill[7:2]
  logic [7:0]        out_tdata;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // predictor copy of registers and state
  logic [8:0]  adv_reg      = ADV_RST;
  logic [12:0] dwell_reg    = DWELL_RST;
  logic        enable_reg   = 1'b1;
  logic        cut_reg      = 1'b0;
  logic        mode_reg     = MODE_SIXTY_TOOTH;
  logic [31:0] last_pulse   = '0;
  logic [31:0] dwell_t0     = '0;
  logic        dwell_active = 1'b0;
  logic [1:0]  coil_sel     = COIL_NONE;
  logic [7:0]  last_tooth   = TOOTH_RST;
  logic        coil_toggle  = 1'b0;
  logic        level_a      = 1'b0;
  logic        level_b      = 1'b0;

  coils_t      coil_levels_due[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned rdy_hold = 0;

  // simulated engine
  logic [31:0] eng_now   = '0;
  logic [31:0] eng_pulse = '0;
  logic [15:0] eng_rpm   = 16'd3000;
  int          eng_tooth = 0;

  ignition_dwell_scheduler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic tick_t mk_tick(input logic [31:0] now_us, input logic [15:0] rpm,
                                    input logic sync_ok, input logic [7:0] tooth,
                                    input logic [31:0] pulse_us);
    tick_t t;
    t.now_us   = now_us;
    t.rpm      = rpm;
    t.sync_ok  = sync_ok;
    t.tooth    = tooth;
    t.pulse_us = pulse_us;
    return t;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_AW-1:0] idx,
                                          input logic [CFG_DW-1:0] val);
    case (idx)
      REG_ADVANCE: begin
        if (val[8:0] < ADV_MIN) adv_reg = ADV_MIN;
        else if (val[8:0] > ADV_MAX) adv_reg = ADV_MAX;
        else adv_reg = val[8:0];
      end
      REG_DWELL: begin
        if (val < DWELL_MIN) dwell_reg = DWELL_MIN;
        else if (val > DWELL_MAX) dwell_reg = DWELL_MAX;
        else dwell_reg = val;
      end
      REG_ENABLE: begin
        enable_reg = val[0];
        if (!val[0]) begin
          level_a      = 1'b0;
          level_b      = 1'b0;
          dwell_active = 1'b0;
        end
      end
      REG_CUT:  cut_reg = val[0];
      REG_MODE: mode_reg = val[0];
      default: ;
    endcase
  endfunction

  function automatic coils_t next_coil_levels(input tick_t t);
    logic [31:0] per_rev;
    logic [31:0] per_deg;
    logic [31:0] adv_us;
    logic [31:0] start_at;
    coils_t      r;
    if (!enable_reg || cut_reg || !t.sync_ok || t.rpm < RPM_MIN) begin
      level_a      = 1'b0;
      level_b      = 1'b0;
      dwell_active = 1'b0;
    end else if (mode_reg == MODE_DISTRIBUTOR) begin
      per_rev  = {6'd0, US_PER_MIN} / {16'd0, t.rpm};
      per_deg  = per_rev / {16'd0, DEG_PER_REV};
      // advance rounded up, so the spark target is rounded down
      adv_us   = ({23'd0, adv_reg} * per_deg + 32'd9) / {16'd0, TENTHS};
      start_at = per_rev - adv_us - {19'd0, dwell_reg};
      if (t.pulse_us != last_pulse) begin
        last_pulse = t.pulse_us;
        if (dwell_active) begin
          level_a      = 1'b0;
          dwell_active = 1'b0;
        end
      end
      if (!dwell_active) begin
        if (t.now_us - last_pulse >= start_at) begin
          level_a      = 1'b1;
          dwell_active = 1'b1;
          dwell_t0     = t.now_us;
          coil_sel     = COIL_A;
        end
      end else if (t.now_us - dwell_t0 >= {19'd0, dwell_reg}) begin
        level_a      = 1'b0;
        dwell_active = 1'b0;
      end
    end else begin
      if (t.tooth != last_tooth) begin
        last_tooth = t.tooth;
        if (t.tooth % TEETH_PER_EVENT == 8'd0 && !dwell_active) begin
          coil_toggle = ~coil_toggle;
          coil_sel    = coil_toggle ? COIL_A : COIL_B;
          if (coil_sel == COIL_A) level_a = 1'b1;
          else level_b = 1'b1;
          dwell_active = 1'b1;
          dwell_t0     = t.now_us;
        end
      end
      if (dwell_active && t.now_us - dwell_t0 >= {19'd0, dwell_reg}) begin
        if (coil_sel == COIL_A) level_a = 1'b0;
        else level_b = 1'b0;
        dwell_active = 1'b0;
      end
    end
    r.coil_a = level_a;
    r.coil_b = level_b;
    return r;
  endfunction

  function automatic int unsigned next_gap();
    int unsigned roll;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_rpm();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 16'($urandom_range(50, 200));
    if (roll < 85) return 16'($urandom_range(600, 7000));
    if (roll < 95) return 16'($urandom_range(7000, 20000));
    return 16'($urandom_range(20000, 65535));
  endfunction

  function automatic tick_t noise_tick();
    tick_t t;
    t = mk_tick($urandom, 16'($urandom), 1'($urandom), 8'($urandom), $urandom);
    case ($urandom_range(0, 2))
      0: ;
      1: begin
        t.now_us  = eng_now;
        t.sync_ok = 1'b0;
      end
      default: begin
        t.now_us  = eng_now;
        t.sync_ok = 1'b1;
        t.rpm     = 16'($urandom_range(0, 49));
      end
    endcase
    return t;
  endfunction

  task automatic flag_mismatch(input string what, input logic want, input logic got);
    $display("%0t: %s expected %0b actual %0b", $time, what, want, got);
    mismatch_count++;
  endtask

  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t.pulse_us, t.tooth, t.rpm, t.now_us};
    in_tuser  <= t.sync_ok;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    coil_levels_due.push_back(next_coil_levels(t));
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg_write(idx, val);
    @(posedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (coil_levels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic shuffle_settings(input logic mode, input bit allow_block);
    logic [CFG_DW-1:0] adv;
    logic [CFG_DW-1:0] dwell;
    adv   = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(50, 400));
    dwell = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(1000, 5000));
    write_reg(REG_MODE, {12'd0, mode});
    write_reg(REG_ADVANCE, adv);
    write_reg(REG_DWELL, dwell);
    write_reg(REG_CUT, {12'd0, allow_block && $urandom_range(0, 7) == 0});
    write_reg(REG_ENABLE, {12'd0, !(allow_block && $urandom_range(0, 7) == 0)});
  endtask

  task automatic crank_wheel_run(input int n);
    tick_t       t;
    int unsigned tooth_us;
    repeat (n) begin
      if ($urandom_range(0, 49) == 0) eng_rpm = pick_rpm();
      tooth_us = 1000000 / eng_rpm;
      if ($urandom_range(0, 99) < 88) begin
        if ($urandom_range(0, 2) != 0) begin
          eng_tooth = (eng_tooth + 1) % 60;
          eng_now   = eng_now + tooth_us;
        end else begin
          eng_now = eng_now + $urandom_range(1, tooth_us);
        end
        t = mk_tick(eng_now, eng_rpm, 1'b1, 8'(eng_tooth), $urandom);
      end else begin
        t = noise_tick();
      end
      send_tick(t);
    end
  endtask

  task automatic distributor_run(input int n);
    tick_t       t;
    int unsigned rev_us;
    repeat (n) begin
      rev_us = US_PER_MIN / eng_rpm;
      if ($urandom_range(0, 99) < 90) begin
        if ($urandom_range(0, 1) != 0) eng_now = eng_now + $urandom_range(1, rev_us / 4 + 1);
        else eng_now = eng_now + $urandom_range(1, 1500);
        // lost track after a big jump: resynchronise on the current time
        if (eng_now - eng_pulse >= 2 * rev_us) begin
          eng_pulse = eng_now;
        end else if (eng_now - eng_pulse >= rev_us) begin
          eng_pulse = eng_pulse + rev_us;
          if ($urandom_range(0, 29) == 0) eng_rpm = pick_rpm();
        end
        t = mk_tick(eng_now, eng_rpm, 1'b1, 8'($urandom), eng_pulse);
      end else begin
        t = noise_tick();
      end
      send_tick(t);
    end
  endtask

  // tooth events, alternation, hold-off, blocked ticks and time wrap
  task automatic test_crank_wheel_events();
    send_tick(mk_tick(32'd1000, 16'd3000, 1'b1, 8'd255, 32'd0));
    send_tick(mk_tick(32'd2000, 16'd3000, 1'b1, 8'd0, 32'd0));
    send_tick(mk_tick(32'd3000, 16'd3000, 1'b1, 8'd0, 32'd0));
    send_tick(mk_tick(32'd4000, 16'd3000, 1'b1, 8'd30, 32'd0));
    send_tick(mk_tick(32'd5500, 16'd3000, 1'b1, 8'd31, 32'd0));
    send_tick(mk_tick(32'd6000, 16'd3000, 1'b1, 8'd30, 32'd0));
    send_tick(mk_tick(32'd9600, 16'd3000, 1'b1, 8'd240, 32'd0));
    send_tick(mk_tick(32'd9700, 16'd3000, 1'b1, 8'd60, 32'd0));
    send_tick(mk_tick(32'd9800, 16'd49, 1'b1, 8'd61, 32'd0));
    send_tick(mk_tick(32'd9900, 16'd3000, 1'b0, 8'd90, 32'd0));
    send_tick(mk_tick(32'd10000, 16'd50, 1'b1, 8'd90, 32'd0));
    send_tick(mk_tick(32'hFFFF_F000, 16'd65535, 1'b1, 8'd120, 32'hFFFF_FFFF));
    send_tick(mk_tick(32'hFFFF_FF00, 16'd65535, 1'b1, 8'd150, 32'hFFFF_FFFF));
    send_tick(mk_tick(32'h0000_0A00, 16'd65535, 1'b1, 8'd151, 32'hFFFF_FFFF));
    send_tick(mk_tick(32'h0000_0E00, 16'd65535, 1'b1, 8'd151, 32'hFFFF_FFFF));
    wait_for_results();
  endtask

  // clamping, unused index, disabling by write and cut
  task automatic test_register_writes();
    write_reg(REG_ADVANCE, 13'd0);
    write_reg(REG_DWELL, 13'd0);
    send_tick(mk_tick(32'd20000, 16'd3000, 1'b1, 8'd180, 32'd0));
    send_tick(mk_tick(32'd20999, 16'd3000, 1'b1, 8'd181, 32'd0));
    send_tick(mk_tick(32'd21000, 16'd3000, 1'b1, 8'd182, 32'd0));
    wait_for_results();
    write_reg(REG_ADVANCE, 13'h1FFF);
    write_reg(REG_DWELL, 13'h1FFF);
    write_reg(REG_UNUSED, 13'h1FFF);
    send_tick(mk_tick(32'd30000, 16'd3000, 1'b1, 8'd210, 32'd0));
    wait_for_results();
    write_reg(REG_ENABLE, 13'd0);
    send_tick(mk_tick(32'd30100, 16'd3000, 1'b1, 8'd211, 32'd0));
    wait_for_results();
    write_reg(REG_ENABLE, 13'h1FFF);
    write_reg(REG_CUT, 13'h1FFF);
    send_tick(mk_tick(32'd30200, 16'd3000, 1'b1, 8'd212, 32'd0));
    wait_for_results();
    write_reg(REG_CUT, 13'd0);
    send_tick(mk_tick(32'd31200, 16'd3000, 1'b1, 8'd240, 32'd0));
    wait_for_results();
  endtask

  // dwell window after a pulse, new pulse ending dwell, late start by wrap;
  // coil B is still charging from the last tooth event and must stay so
  task automatic test_distributor_window();
    write_reg(REG_MODE, {12'd0, MODE_DISTRIBUTOR});
    send_tick(mk_tick(32'd100010, 16'd1000, 1'b1, 8'd0, 32'd100000));
    send_tick(mk_tick(32'd148359, 16'd1000, 1'b1, 8'd0, 32'd100000));
    send_tick(mk_tick(32'd148360, 16'd1000, 1'b1, 8'd0, 32'd100000));
    send_tick(mk_tick(32'd153360, 16'd1000, 1'b1, 8'd0, 32'd100000));
    send_tick(mk_tick(32'd159000, 16'd1000, 1'b1, 8'd0, 32'd100000));
    send_tick(mk_tick(32'd160005, 16'd1000, 1'b1, 8'd0, 32'd160000));
    send_tick(mk_tick(32'd159900, 16'd20000, 1'b1, 8'd0, 32'd160000));
    send_tick(mk_tick(32'd165000, 16'd65535, 1'b1, 8'd0, 32'd160000));
    wait_for_results();
  endtask

  task automatic test_random_crank_wheel(input int n);
    shuffle_settings(MODE_SIXTY_TOOTH, 1'b0);
    eng_now   = $urandom;
    eng_tooth = 0;
    eng_rpm   = pick_rpm();
    crank_wheel_run(n);
    wait_for_results();
  endtask

  task automatic test_random_distributor(input int n);
    shuffle_settings(MODE_DISTRIBUTOR, 1'b0);
    // start close to the wrap of the time counter
    eng_now   = 32'hFFF0_0000 + $urandom_range(0, 65535);
    eng_pulse = eng_now;
    eng_rpm   = pick_rpm();
    distributor_run(n);
    wait_for_results();
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    repeat (phases) begin
      shuffle_settings(1'($urandom), 1'b1);
      eng_pulse = eng_now;
      if (mode_reg == MODE_DISTRIBUTOR) distributor_run(per_phase);
      else crank_wheel_run(per_phase);
      wait_for_results();
    end
  endtask

  // result side pacing: short stalls, long stalls and calm stretches
  always @(posedge clk) begin : sink_pacing
    int unsigned roll;
    if (rdy_hold != 0) begin
      rdy_hold <= rdy_hold - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        out_tready <= 1'b1;
        rdy_hold   <= $urandom_range(0, 6);
      end else if (roll < 85) begin
        out_tready <= 1'b0;
        rdy_hold   <= $urandom_range(0, 3);
      end else if (roll < 97) begin
        out_tready <= 1'b1;
        rdy_hold   <= $urandom_range(50, 200);
      end else begin
        out_tready <= 1'b0;
        rdy_hold   <= $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk) begin : coil_check
    coils_t got;
    coils_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = coils_t'(out_tdata[1:0]);
      if (coil_levels_due.size() == 0) begin
        $display("%0t: no transfer expected, actual a=%0b b=%0b", $time,
                 got.coil_a, got.coil_b);
        mismatch_count++;
      end else begin
        want = coil_levels_due.pop_front();
        if (got.coil_a !== want.coil_a) flag_mismatch("coil_a_on", want.coil_a, got.coil_a);
        if (got.coil_b !== want.coil_b) flag_mismatch("coil_b_on", want.coil_b, got.coil_b);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin : watchdog_stop
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_crank_wheel_events();
    test_register_writes();
    test_distributor_window();
    test_random_crank_wheel(400);
    test_random_distributor(400);
    test_random_settings(11, 50);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && coil_levels_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### ignition_dwell_scheduler.f
sv/ids_pkg.sv
sv/ignition_dwell_scheduler.sv
sv/ids_checker.sv
tb/tb_ignition_dwell_scheduler.sv
